>>> src/csvt_pkg.sv
// Shared types and constants of the CSV field tokenizer.
package csvt_pkg;

    // Special byte values
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_STRAY    = 3'd1;
    localparam logic [2:0] ERR_CR_NO_LF = 3'd2;
    localparam logic [2:0] ERR_UNCLOSED = 3'd3;
    localparam logic [2:0] ERR_END_CR   = 3'd4;
    localparam logic [2:0] ERR_MISMATCH = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEPARATOR   = 2'd0;
    localparam logic [1:0] CFG_MAX_RECORDS = 2'd1;
    localparam logic [1:0] CFG_STRICT_MODE = 2'd2;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_end;
        logic       record_end;
        logic [7:0] field_count;
        logic [2:0] error_code;
        logic       limit_reached;
    } t_out;

    // Parser flags that travel between the state registers and the step logic
    typedef struct packed {
        logic in_quotes;
        logic quote_pending;
        logic cr_pending;
        logic field_has_content;
        logic halted_on_error;
    } t_flags;

    // Configuration as seen by the step logic
    typedef struct packed {
        logic [7:0]  separator;
        logic [15:0] max_records;
        logic        strict_mode;
    } t_cfg;

endpackage

>>> src/csv_field_tokenizer_core.sv
// Top level of the CSV field tokenizer: input stage, state, result register, config.
// A byte accepted into the input register moves on to the result register when that is free.
// Throughput: one byte per cycle while the result channel does not stall; the parser state
//   updates in a single registered pass as a byte moves from the input register to the result register.
// Reset (i_rst_n low, synchronous): both stages empty, parser state cleared,
//   separator back to comma, max_records and strict_mode to zero.
module csv_field_tokenizer_core #(
    parameter int COUNT_WIDTH        = 8,
    parameter int RECORD_COUNT_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input byte channel
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  csvt_pkg::t_in   i_in_data,
    // result channel
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output csvt_pkg::t_out  o_out_data,
    // configuration write port
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_wdata
);

    // input register
    logic                          r_s1_valid;
    csvt_pkg::t_in                 r_s1_data;
    // result register
    logic                          r_out_valid;
    csvt_pkg::t_out                r_out_data;
    // parser state
    csvt_pkg::t_flags              r_flags;
    logic [COUNT_WIDTH-1:0]        r_fields;
    logic [COUNT_WIDTH-1:0]        r_first_fields;
    logic [RECORD_COUNT_WIDTH-1:0] r_records;
    // configuration
    csvt_pkg::t_cfg                r_cfg;

    csvt_pkg::t_out                n_result;
    csvt_pkg::t_flags              n_flags;
    logic [COUNT_WIDTH-1:0]        n_fields;
    logic [COUNT_WIDTH-1:0]        n_first_fields;
    logic [RECORD_COUNT_WIDTH-1:0] n_records;

    logic out_load;   // result register can take a new result
    logic s1_fire;    // the buffered byte moves on and updates the state

    assign out_load    = !r_out_valid || i_out_ready;
    assign s1_fire     = r_s1_valid && out_load;
    assign o_in_ready  = !r_s1_valid || out_load;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    csvt_step #(
        .COUNT_WIDTH        (COUNT_WIDTH),
        .RECORD_COUNT_WIDTH (RECORD_COUNT_WIDTH)
    ) u_step (
        .i_item         (r_s1_data),
        .i_cfg          (r_cfg),
        .i_flags        (r_flags),
        .i_fields       (r_fields),
        .i_first_fields (r_first_fields),
        .i_records      (r_records),
        .o_result       (n_result),
        .o_flags        (n_flags),
        .o_fields       (n_fields),
        .o_first_fields (n_first_fields),
        .o_records      (n_records)
    );

    // Control, state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_flags           <= '0;
            r_fields          <= '0;
            r_first_fields    <= '0;
            r_records         <= '0;
            r_cfg.separator   <= csvt_pkg::SEPARATOR_RESET;
            r_cfg.max_records <= '0;
            r_cfg.strict_mode <= 1'b0;
        end else begin
            // hold the input stage until the result register frees up
            if (o_in_ready) r_s1_valid <= i_in_valid;
            if (out_load) r_out_valid <= r_s1_valid;
            // advance the parser state only when the byte leaves the input stage
            if (s1_fire) begin
                r_flags        <= n_flags;
                r_fields       <= n_fields;
                r_first_fields <= n_first_fields;
                r_records      <= n_records;
            end
            // drop writes to indexes beyond the register list
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    csvt_pkg::CFG_SEPARATOR:   r_cfg.separator   <= i_cfg_wdata[7:0];
                    csvt_pkg::CFG_MAX_RECORDS: r_cfg.max_records <= i_cfg_wdata;
                    csvt_pkg::CFG_STRICT_MODE: r_cfg.strict_mode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_s1_data <= i_in_data;
        if (s1_fire) r_out_data <= n_result;
    end

    // An error result carries nothing but its code
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.error_code != csvt_pkg::ERR_NONE))
        |-> (!r_out_data.byte_valid && !r_out_data.field_end
             && !r_out_data.record_end && !r_out_data.limit_reached))
        else $error("error result carries other fields");

    // A record never ends without its last field ending
    a_rec_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.record_end) |-> r_out_data.field_end)
        else $error("record_end without field_end");

    // An error inside the stream halts the parser
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && (n_result.error_code != csvt_pkg::ERR_NONE)
         && !r_s1_data.end_of_stream) |=> r_flags.halted_on_error)
        else $error("error did not halt the parser");

    // The end of the stream clears the counts
    a_eos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_data.end_of_stream)
        |=> ((r_records == '0) && (r_fields == '0) && (r_flags == '0)))
        else $error("state not cleared at end of stream");

    // A result appears only after a byte left the input stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_fire))
        else $error("result without a request");

endmodule

>>> src/csvt_step.sv
// One-byte state update and result of the CSV field tokenizer.
module csvt_step #(
    parameter int COUNT_WIDTH        = 8,
    parameter int RECORD_COUNT_WIDTH = 16
) (
    input  csvt_pkg::t_in                 i_item,
    input  csvt_pkg::t_cfg                i_cfg,
    input  csvt_pkg::t_flags              i_flags,
    input  logic [COUNT_WIDTH-1:0]        i_fields,
    input  logic [COUNT_WIDTH-1:0]        i_first_fields,
    input  logic [RECORD_COUNT_WIDTH-1:0] i_records,
    output csvt_pkg::t_out                o_result,
    output csvt_pkg::t_flags              o_flags,
    output logic [COUNT_WIDTH-1:0]        o_fields,
    output logic [COUNT_WIDTH-1:0]        o_first_fields,
    output logic [RECORD_COUNT_WIDTH-1:0] o_records
);

    localparam int CMP_W = (RECORD_COUNT_WIDTH > 16) ? RECORD_COUNT_WIDTH : 16;
    localparam int FC_W  = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

    logic [7:0]             b;
    logic                   eos;
    logic                   limited;
    logic                   do_close;
    logic [2:0]             err;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [FC_W-1:0]        cnt_x;

    assign b   = i_item.in_byte;
    assign eos = i_item.end_of_stream;
    assign limited = (i_cfg.max_records != 16'd0)
                  && (CMP_W'(i_records) >= CMP_W'(i_cfg.max_records));

    always_comb begin
        o_result       = '0;
        o_flags        = i_flags;
        o_fields       = i_fields;
        o_first_fields = i_first_fields;
        o_records      = i_records;
        do_close       = 1'b0;
        err            = csvt_pkg::ERR_NONE;
        cnt            = '0;
        cnt_x          = '0;

        if (i_flags.halted_on_error) begin
            // drop the byte
        end else if (limited) begin
            o_result.limit_reached = 1'b1;
        end else begin
            if (i_flags.cr_pending) begin
                if (b != csvt_pkg::CH_LF) begin
                    err = csvt_pkg::ERR_CR_NO_LF;
                end else begin
                    do_close = 1'b1;
                end
            end else if (i_flags.in_quotes && i_flags.quote_pending) begin
                o_flags.quote_pending = 1'b0;
                if (b == csvt_pkg::CH_QUOTE) begin
                    o_result.out_byte   = b;
                    o_result.byte_valid = 1'b1;
                end else begin
                    o_flags.in_quotes = 1'b0;
                    if (b == csvt_pkg::CH_CR) begin
                        o_flags.cr_pending = 1'b1;
                    end else if (b == csvt_pkg::CH_LF) begin
                        do_close = 1'b1;
                    end else if (b == i_cfg.separator) begin
                        if (o_fields != '1) o_fields = o_fields + COUNT_WIDTH'(1);
                        o_flags.field_has_content = 1'b0;
                        o_result.field_end        = 1'b1;
                    end else begin
                        err = csvt_pkg::ERR_STRAY;
                    end
                end
            end else if (i_flags.in_quotes) begin
                if (b == csvt_pkg::CH_QUOTE) begin
                    o_flags.quote_pending = 1'b1;
                end else begin
                    o_result.out_byte   = b;
                    o_result.byte_valid = 1'b1;
                end
            end else begin
                if (b == csvt_pkg::CH_QUOTE) begin
                    if (i_flags.field_has_content) err = csvt_pkg::ERR_STRAY;
                    else o_flags.in_quotes = 1'b1;
                end else if (b == csvt_pkg::CH_CR) begin
                    o_flags.cr_pending = 1'b1;
                end else if (b == csvt_pkg::CH_LF) begin
                    do_close = 1'b1;
                end else if (b == i_cfg.separator) begin
                    if (o_fields != '1) o_fields = o_fields + COUNT_WIDTH'(1);
                    o_flags.field_has_content = 1'b0;
                    o_result.field_end        = 1'b1;
                end else begin
                    o_result.out_byte         = b;
                    o_result.byte_valid       = 1'b1;
                    o_flags.field_has_content = 1'b1;
                end
            end

            // close an unfinished record at the end of the stream, or flag an unclosed quote or a trailing CR
            if (eos && (err == csvt_pkg::ERR_NONE) && !do_close) begin
                if (o_flags.in_quotes && !o_flags.quote_pending) begin
                    err = csvt_pkg::ERR_UNCLOSED;
                end else if (o_flags.cr_pending) begin
                    err = csvt_pkg::ERR_END_CR;
                end else begin
                    do_close = 1'b1;
                end
            end

            if (do_close) begin
                cnt = o_fields;
                if (cnt != '1) cnt = cnt + COUNT_WIDTH'(1);
                if (i_records == '0) begin
                    o_first_fields = cnt;
                end else if (i_cfg.strict_mode && (cnt != i_first_fields)) begin
                    err = csvt_pkg::ERR_MISMATCH;
                end
                if (err == csvt_pkg::ERR_NONE) begin
                    cnt_x = FC_W'(cnt);
                    o_result.field_end   = 1'b1;
                    o_result.record_end  = 1'b1;
                    o_result.field_count = (cnt_x > FC_W'(8'hFF)) ? 8'hFF : cnt_x[7:0];
                    if (o_records != '1) o_records = o_records + RECORD_COUNT_WIDTH'(1);
                    o_fields                  = '0;
                    o_flags.field_has_content = 1'b0;
                    o_flags.in_quotes         = 1'b0;
                    o_flags.quote_pending     = 1'b0;
                    o_flags.cr_pending        = 1'b0;
                end
            end

            if (err != csvt_pkg::ERR_NONE) begin
                o_result            = '0;
                o_result.error_code = err;
                o_flags.halted_on_error = 1'b1;
            end
        end

        // the end of the stream returns every parser state to reset
        if (eos) begin
            o_flags        = '0;
            o_fields       = '0;
            o_first_fields = '0;
            o_records      = '0;
        end
    end

endmodule

>>> test/tb.sv
// Self-checking testbench for the CSV field tokenizer core.
module tb;

    localparam int CYCLE_LIMIT = 600000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            in_valid = 1'b0;
    csvt_pkg::t_in   in_data = '0;
    logic            out_ready = 1'b1;
    logic            cfg_we = 1'b0;
    logic [1:0]      cfg_index = csvt_pkg::CFG_SEPARATOR;
    logic [15:0]     cfg_wdata = '0;
    logic            o_in_ready;
    logic            o_out_valid;
    csvt_pkg::t_out  o_out_data;

    csv_field_tokenizer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Tokenizer state as the testbench sees it
    logic [7:0]      sep_reg = csvt_pkg::SEPARATOR_RESET;
    logic [15:0]     max_rec_reg = '0;
    logic            strict_reg = 1'b0;
    logic            quoted, quote_seen, cr_seen, has_text, halted;
    logic [7:0]      fld_count, first_count;
    logic [15:0]     rec_count;
    csvt_pkg::t_out  step_tok;

    csvt_pkg::t_out  expected_tokens[$];
    logic [7:0]      stream_q[$];
    int unsigned     mismatches = 0;
    int unsigned     items_sent = 0;
    int unsigned     cycles = 0;
    int unsigned     hold_left = 0;
    bit              pace_on = 1'b1;
    csvt_pkg::t_out  want_tok;

    // ---------------------------------------------------------------
    // Token prediction
    // ---------------------------------------------------------------
    function automatic void clear_parser();
        quoted      = 1'b0;
        quote_seen  = 1'b0;
        cr_seen     = 1'b0;
        has_text    = 1'b0;
        halted      = 1'b0;
        fld_count   = '0;
        first_count = '0;
        rec_count   = '0;
    endfunction

    function automatic void put_content(input logic [7:0] b);
        step_tok.out_byte   = b;
        step_tok.byte_valid = 1'b1;
    endfunction

    function automatic void end_field();
        if (fld_count != 8'hFF) fld_count++;
        has_text = 1'b0;
        step_tok.field_end = 1'b1;
    endfunction

    // Close the record; a strict-mode count mismatch leaves the state alone
    function automatic logic [2:0] end_record();
        logic [7:0] cnt;
        cnt = fld_count;
        if (cnt != 8'hFF) cnt++;
        if (rec_count == 0) begin
            first_count = cnt;
        end else if (strict_reg && cnt != first_count) begin
            return csvt_pkg::ERR_MISMATCH;
        end
        step_tok.field_end   = 1'b1;
        step_tok.record_end  = 1'b1;
        step_tok.field_count = cnt;
        if (rec_count != 16'hFFFF) rec_count++;
        fld_count  = '0;
        has_text   = 1'b0;
        quoted     = 1'b0;
        quote_seen = 1'b0;
        cr_seen    = 1'b0;
        return csvt_pkg::ERR_NONE;
    endfunction

    function automatic csvt_pkg::t_out tokenize_byte(input logic [7:0] b, input logic eos);
        logic [2:0] err;
        logic       closed;
        err      = csvt_pkg::ERR_NONE;
        closed   = 1'b0;
        step_tok = '0;
        if (halted) begin
            // drop everything until the end of the stream
        end else if (max_rec_reg != 0 && rec_count >= max_rec_reg) begin
            step_tok.limit_reached = 1'b1;
        end else begin
            if (cr_seen) begin
                if (b != csvt_pkg::CH_LF) begin
                    err = csvt_pkg::ERR_CR_NO_LF;
                end else begin
                    err = end_record();
                    closed = 1'b1;
                end
            end else if (quoted && quote_seen) begin
                quote_seen = 1'b0;
                if (b == csvt_pkg::CH_QUOTE) begin
                    put_content(b);
                end else begin
                    // closing quote: only a line end or a separator may follow
                    quoted = 1'b0;
                    if (b == csvt_pkg::CH_CR) begin
                        cr_seen = 1'b1;
                    end else if (b == csvt_pkg::CH_LF) begin
                        err = end_record();
                        closed = 1'b1;
                    end else if (b == sep_reg) begin
                        end_field();
                    end else begin
                        err = csvt_pkg::ERR_STRAY;
                    end
                end
            end else if (quoted) begin
                if (b == csvt_pkg::CH_QUOTE) quote_seen = 1'b1;
                else put_content(b);
            end else begin
                if (b == csvt_pkg::CH_QUOTE) begin
                    if (has_text) err = csvt_pkg::ERR_STRAY;
                    else quoted = 1'b1;
                end else if (b == csvt_pkg::CH_CR) begin
                    cr_seen = 1'b1;
                end else if (b == csvt_pkg::CH_LF) begin
                    err = end_record();
                    closed = 1'b1;
                end else if (b == sep_reg) begin
                    end_field();
                end else begin
                    put_content(b);
                    has_text = 1'b1;
                end
            end

            // close whatever is left open at the end of the stream, or flag an unclosed quote or a trailing CR
            if (eos && err == csvt_pkg::ERR_NONE && !closed) begin
                if (quoted && !quote_seen) err = csvt_pkg::ERR_UNCLOSED;
                else if (cr_seen) err = csvt_pkg::ERR_END_CR;
                else err = end_record();
            end

            if (err != csvt_pkg::ERR_NONE) begin
                step_tok = '0;
                step_tok.error_code = err;
                halted = 1'b1;
            end
        end
        if (eos) clear_parser();
        return step_tok;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int unsigned    gap;
        csvt_pkg::t_in  req;
        csvt_pkg::t_out tok;
        gap = pace_on ? $urandom_range(0, 11) : 0;
        req.in_byte       = b;
        req.end_of_stream = eos;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        tok = tokenize_byte(b, eos);
        expected_tokens = {expected_tokens, tok};
    endtask

    task automatic send_text(input string s, input bit eos_last);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], eos_last && i == s.len() - 1);
    endtask

    // Hold off until every token is back, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all three registers back to back; junk in the unused upper bits
    task automatic apply_config(input logic [7:0] sep, input logic [15:0] lim,
                                input logic strict_on);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= csvt_pkg::CFG_SEPARATOR;
        cfg_wdata <= {8'($urandom), sep};
        @(posedge i_clk);
        cfg_index <= csvt_pkg::CFG_MAX_RECORDS;
        cfg_wdata <= lim;
        @(posedge i_clk);
        cfg_index <= csvt_pkg::CFG_STRICT_MODE;
        cfg_wdata <= {15'($urandom), strict_on};
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        sep_reg     = sep;
        max_rec_reg = lim;
        strict_reg  = strict_on;
    endtask

    // ---------------------------------------------------------------
    // Random stream generation
    // ---------------------------------------------------------------
    function automatic void queue_byte(input logic [7:0] b);
        stream_q = {stream_q, b};
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
        end while (b == csvt_pkg::CH_QUOTE || b == csvt_pkg::CH_CR
                   || b == csvt_pkg::CH_LF || b == sep_reg);
        return b;
    endfunction

    function automatic void push_record(input int unsigned nfields);
        int unsigned len;
        for (int f = 0; f < nfields; f++) begin
            if (f != 0) queue_byte(sep_reg);
            len = $urandom_range(0, 4);
            if ($urandom_range(0, 2) == 0) begin
                // quoted field: separators, line ends and doubled quotes are content
                queue_byte(csvt_pkg::CH_QUOTE);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            queue_byte(csvt_pkg::CH_QUOTE);
                            queue_byte(csvt_pkg::CH_QUOTE);
                        end
                        1: queue_byte(sep_reg);
                        2: queue_byte($urandom_range(0, 1) ? csvt_pkg::CH_CR : csvt_pkg::CH_LF);
                        default: queue_byte(plain_byte());
                    endcase
                end
                queue_byte(csvt_pkg::CH_QUOTE);
            end else begin
                for (int k = 0; k < len; k++) queue_byte(plain_byte());
            end
        end
        if ($urandom_range(0, 3) != 0) queue_byte(csvt_pkg::CH_CR);
        queue_byte(csvt_pkg::CH_LF);
    endfunction

    // Send whole streams until enough bytes have been sent
    task automatic run_streams(input int unsigned n_items, input int unsigned max_fields);
        int unsigned start;
        int unsigned fields;
        logic [7:0]  junk;
        start = items_sent;
        while (items_sent - start < n_items) begin
            stream_q.delete();
            fields = $urandom_range(1, max_fields);
            repeat ($urandom_range(1, 6)) begin
                push_record((strict_reg && $urandom_range(0, 7) != 0) ?
                            fields : $urandom_range(1, max_fields));
            end
            // sometimes end the stream in the middle of a record
            if ($urandom_range(0, 3) == 0 && stream_q.size() > 1) void'(stream_q.pop_back());
            // and sometimes break it with a misplaced byte
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 4))
                    0: junk = csvt_pkg::CH_QUOTE;
                    1: junk = csvt_pkg::CH_CR;
                    2: junk = csvt_pkg::CH_LF;
                    3: junk = sep_reg;
                    default: junk = 8'($urandom);
                endcase
                stream_q.insert($urandom_range(0, stream_q.size() - 1), junk);
            end
            for (int i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset configuration: extreme bytes, doubled quote, empty field, CRLF,
    // closing quote then LF, bare LF, record closed by the end of the stream
    task automatic test_clean_records();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text(",\"\"\"\",\r\n", 1'b0);
        send_text("\"\"\n", 1'b0);
        send_text("c\nd", 1'b1);
    endtask

    // Each error but the count mismatch, in its own stream; bytes after an error are dropped until the stream ends
    task automatic test_error_codes();
        send_text("a\"b", 1'b1);
        send_text("\"\"x", 1'b1);
        send_text("\rz", 1'b1);
        send_text("\"\n", 1'b1);
        send_text("\r", 1'b1);
    endtask

    // Field count saturates; strict mode still compares saturated counts
    task automatic test_count_saturation();
        apply_config(",", 16'd0, 1'b1);
        pace_on = 1'b0;
        repeat (300) send_byte(",", 1'b0);
        send_text("\r\n", 1'b0);
        repeat (260) send_byte(",", 1'b0);
        send_text("\na\nq", 1'b1);
        pace_on = 1'b1;
    endtask

    task automatic test_random_default();
        apply_config(",", 16'd0, 1'b0);
        run_streams(200, 5);
    endtask

    task automatic test_strict_mode();
        apply_config(";", 16'd0, 1'b1);
        run_streams(150, 4);
    endtask

    task automatic test_record_limit();
        apply_config(8'h00, 16'd3, 1'b0);
        run_streams(80, 4);
        apply_config(",", 16'd1, 1'b0);
        run_streams(40, 4);
    endtask

    task automatic test_separator_extremes();
        apply_config(8'hFF, 16'hFFFF, 1'b1);
        run_streams(100, 5);
    endtask

    // Separator equal to quote, CR or LF: those meanings take priority
    task automatic test_separator_specials();
        apply_config(csvt_pkg::CH_QUOTE, 16'd0, 1'b0);
        run_streams(40, 4);
        apply_config(csvt_pkg::CH_CR, 16'd0, 1'b1);
        run_streams(40, 4);
        apply_config(csvt_pkg::CH_LF, 16'd2, 1'b0);
        run_streams(40, 4);
    endtask

    // Full rate on both sides
    task automatic test_back_to_back();
        apply_config(8'h09, 16'd0, 1'b0);
        pace_on = 1'b0;
        run_streams(100, 5);
        pace_on = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Token side: stall at random and check each token in order
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] got);
        if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: %s mismatch: expected %0h, got %0h", name, exp, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("tb: token with no request waiting");
            end else begin
                want_tok = expected_tokens.pop_front();
                check_field("out_byte", want_tok.out_byte, o_out_data.out_byte);
                check_field("byte_valid", 8'(want_tok.byte_valid),
                            8'(o_out_data.byte_valid));
                check_field("field_end", 8'(want_tok.field_end), 8'(o_out_data.field_end));
                check_field("record_end", 8'(want_tok.record_end),
                            8'(o_out_data.record_end));
                check_field("field_count", want_tok.field_count, o_out_data.field_count);
                check_field("error_code", 8'(want_tok.error_code),
                            8'(o_out_data.error_code));
                check_field("limit_reached", 8'(want_tok.limit_reached),
                            8'(o_out_data.limit_reached));
            end
            hold_left = pace_on ? $urandom_range(0, 11) : 0;
            if (hold_left != 0) out_ready <= 1'b0;
        end else if (!out_ready) begin
            if (hold_left > 1) hold_left--;
            else out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        clear_parser();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_clean_records();
        test_error_codes();
        test_count_saturation();
        test_random_default();
        test_strict_mode();
        test_record_limit();
        test_separator_extremes();
        test_separator_specials();
        test_back_to_back();
        drain();
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/csvt_pkg.sv
src/csvt_step.sv
src/csv_field_tokenizer_core.sv
test/tb.sv
